/* src/bert_pkg.sv */
// ----------------------------------------------------------------------------
// bert_pkg: shared definitions for the button edge and repeat tracker
// Widths, register indexes, direction masks and saturating time helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bert_pkg;

	localparam int BUTTONS    = 22;
	localparam int TIMER_BITS = 16;
	localparam int ELAPSED_W  = 10;
	localparam int PERIOD_W   = 16;
	localparam int THR_W      = 7;
	localparam int QUERY_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [63:0] TMR_MAX = (64'd1 << TIMER_BITS) - 64'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR    = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd350;
	localparam logic [THR_W-1:0]    THR_RESET    = 7'd50;

	localparam logic [BUTTONS-1:0] DIR_UP_M    = BUTTONS'(32'h10);
	localparam logic [BUTTONS-1:0] DIR_RIGHT_M = BUTTONS'(32'h20);
	localparam logic [BUTTONS-1:0] DIR_DOWN_M  = BUTTONS'(32'h40);
	localparam logic [BUTTONS-1:0] DIR_LEFT_M  = BUTTONS'(32'h80);
	localparam logic [BUTTONS-1:0] DIR_ALL_M   = BUTTONS'(32'hF0);

	typedef struct packed {
		logic en;
		logic press;
		logic rel;
		logic held;
	} lane_ctl_t;

	function automatic logic [TIMER_BITS-1:0] sat_add(
		input logic [TIMER_BITS-1:0] a,
		input logic [ELAPSED_W-1:0]  b
	);
		logic [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > TMR_MAX[32:0])
			return TMR_MAX[TIMER_BITS-1:0];
		return s[TIMER_BITS-1:0];
	endfunction

	function automatic logic [TIMER_BITS-1:0] sat_reload(input logic [PERIOD_W-1:0] p);
		if (64'(p) > TMR_MAX)
			return TMR_MAX[TIMER_BITS-1:0];
		return TIMER_BITS'(p);
	endfunction

endpackage

/* src/bert_rpt_timer.sv */
// ----------------------------------------------------------------------------
// bert_rpt_timer: repeat count-down timer
// Counts down by the elapsed time, fires and reloads on expiry, clears idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bert_rpt_timer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             active,
	input  logic [bert_pkg::ELAPSED_W-1:0]   elapsed,
	input  logic [bert_pkg::TIMER_BITS-1:0]  reload,
	output logic                             fire
);

	logic [bert_pkg::TIMER_BITS-1:0] t_q;

	assign fire = active && (33'(elapsed) >= 33'(t_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else if (en) begin
			if (!active)
				t_q <= '0;
			else if (fire)
				t_q <= reload;
			else
				t_q <= bert_pkg::TIMER_BITS'(33'(t_q) - 33'(elapsed));
		end
	end

endmodule

/* src/bert_lane.sv */
// ----------------------------------------------------------------------------
// bert_lane: per-button hold and release time counters
// Clear on edge, then add elapsed time to the hold or release count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bert_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bert_pkg::lane_ctl_t              ctl,
	input  logic [bert_pkg::ELAPSED_W-1:0]   elapsed,
	output logic [bert_pkg::TIMER_BITS-1:0]  down_nxt,
	output logic [bert_pkg::TIMER_BITS-1:0]  up_nxt
);

	logic [bert_pkg::TIMER_BITS-1:0] down_q;
	logic [bert_pkg::TIMER_BITS-1:0] up_q;

	always_comb begin
		logic [bert_pkg::TIMER_BITS-1:0] d;
		logic [bert_pkg::TIMER_BITS-1:0] u;
		d = down_q;
		u = up_q;
		if (ctl.press)
			d = '0;
		else if (ctl.rel)
			u = '0;
		if (ctl.held)
			d = bert_pkg::sat_add(d, elapsed);
		else
			u = bert_pkg::sat_add(u, elapsed);
		down_nxt = ctl.en ? d : down_q;
		up_nxt   = ctl.en ? u : up_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= '0;
			up_q   <= '0;
		end else begin
			down_q <= down_nxt;
			up_q   <= up_nxt;
		end
	end

endmodule

/* src/button_edge_repeat_tracker_top.sv */
// ----------------------------------------------------------------------------
// button_edge_repeat_tracker_top: button edge detector with auto-repeat
// Tracks held, pressed and released buttons plus per-button hold times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one pad tick per beat: the
//   sample flag, raw buttons, stick position, elapsed ms and a query index.
//   Output channel (out_valid / out_ready) gives one result beat per input
//   beat: held, pressed and released masks and the queried button's times.
//   Configuration is written through cfg_we / cfg_index / cfg_data while
//   the block is idle.
//   Path: an accepted beat is captured in the input register, then moves
//   to the result register, where it is presented as output valid.
//   Throughput: one beat per cycle while out_ready is high; the whole tick
//   (stick timer, 22 button counters and direction timer) is evaluated
//   combinationally between the input register and the result register.
//   Reset: held state, button times and timers clear; mode off, period 350 ms,
//   threshold 50.
//   Stall: while out_ready is low the result holds; one further beat is
//   taken into the input register, then in_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_edge_repeat_tracker_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bert_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bert_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               sample_valid,
	input  logic [bert_pkg::BUTTONS-1:0]       button_bits,
	input  logic signed [7:0]                  stick_x,
	input  logic signed [7:0]                  stick_y,
	input  logic [bert_pkg::ELAPSED_W-1:0]     elapsed_ms,
	input  logic [bert_pkg::QUERY_W-1:0]       query_button,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bert_pkg::BUTTONS-1:0]       held_mask,
	output logic [bert_pkg::BUTTONS-1:0]       pressed_mask,
	output logic [bert_pkg::BUTTONS-1:0]       released_mask,
	output logic [bert_pkg::TIMER_BITS-1:0]    query_down_ms,
	output logic [bert_pkg::TIMER_BITS-1:0]    query_up_ms
);

	localparam int NB = bert_pkg::BUTTONS;
	localparam int TB = bert_pkg::TIMER_BITS;

	logic                            mode_q;
	logic [bert_pkg::PERIOD_W-1:0]   period_q;
	logic [bert_pkg::THR_W-1:0]      thr_q;

	logic                            vld_s1;
	logic                            sv_s1;
	logic [NB-1:0]                   btn_s1;
	logic signed [7:0]               sx_s1;
	logic signed [7:0]               sy_s1;
	logic [bert_pkg::ELAPSED_W-1:0]  el_s1;
	logic [bert_pkg::QUERY_W-1:0]    q_s1;

	logic [NB-1:0]                   held_q;

	logic                            adv;
	logic                            upd;
	logic                            tmr_en;
	logic signed [8:0]               sx9;
	logic signed [8:0]               sy9;
	logic signed [8:0]               thr9;
	logic signed [8:0]               nthr9;
	logic [NB-1:0]                   dirs;
	logic                            stick_fire;
	logic [NB-1:0]                   sample;
	logic [NB-1:0]                   press_e;
	logic [NB-1:0]                   rel_e;
	logic                            dir_active;
	logic                            dir_fire;
	logic [NB-1:0]                   rpt;
	logic [TB-1:0]                   reload;
	logic [NB-1:0][TB-1:0]           down_nxt;
	logic [NB-1:0][TB-1:0]           up_nxt;
	logic [TB-1:0]                   qd;
	logic [TB-1:0]                   qu;
	bert_pkg::lane_ctl_t             lane_ctl [NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			period_q <= bert_pkg::PERIOD_RESET;
			thr_q    <= bert_pkg::THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bert_pkg::CFG_MODE:   mode_q   <= cfg_data[0];
				bert_pkg::CFG_PERIOD: period_q <= cfg_data[bert_pkg::PERIOD_W-1:0];
				bert_pkg::CFG_THR:    thr_q    <= cfg_data[bert_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = vld_s1 && (!out_valid || out_ready);
	assign in_ready = !vld_s1 || adv;
	assign upd      = adv && sv_s1;
	assign tmr_en   = upd && mode_q;
	assign reload   = bert_pkg::sat_reload(period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sv_s1  <= sample_valid;
			btn_s1 <= button_bits;
			sx_s1  <= stick_x;
			sy_s1  <= stick_y;
			el_s1  <= elapsed_ms;
			q_s1   <= query_button;
		end
	end

	always_comb begin
		logic [NB-1:0] d;
		sx9   = {sx_s1[7], sx_s1};
		sy9   = {sy_s1[7], sy_s1};
		thr9  = {2'b00, thr_q};
		nthr9 = -thr9;
		d = '0;
		if (sx9 >= thr9)
			d = d | bert_pkg::DIR_RIGHT_M;
		else if (sx9 <= nthr9)
			d = d | bert_pkg::DIR_LEFT_M;
		if (sy9 >= thr9)
			d = d | bert_pkg::DIR_DOWN_M;
		else if (sy9 <= nthr9)
			d = d | bert_pkg::DIR_UP_M;
		dirs = d;
	end

	bert_rpt_timer u_stick_tmr (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (tmr_en),
		.active  (dirs != '0),
		.elapsed (el_s1),
		.reload  (reload),
		.fire    (stick_fire)
	);

	assign sample     = btn_s1 | ((mode_q && stick_fire) ? dirs : '0);
	assign press_e    = sample & ~held_q;
	assign rel_e      = held_q & ~sample;
	assign dir_active = (sample & bert_pkg::DIR_ALL_M) != '0;

	bert_rpt_timer u_dir_tmr (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (tmr_en),
		.active  (dir_active),
		.elapsed (el_s1),
		.reload  (reload),
		.fire    (dir_fire)
	);

	always_comb begin
		rpt = '0;
		if ((sample & bert_pkg::DIR_UP_M) != '0)
			rpt = rpt | bert_pkg::DIR_UP_M;
		else if ((sample & bert_pkg::DIR_DOWN_M) != '0)
			rpt = rpt | bert_pkg::DIR_DOWN_M;
		if ((sample & bert_pkg::DIR_LEFT_M) != '0)
			rpt = rpt | bert_pkg::DIR_LEFT_M;
		else if ((sample & bert_pkg::DIR_RIGHT_M) != '0)
			rpt = rpt | bert_pkg::DIR_RIGHT_M;
	end

	for (genvar i = 0; i < NB; i++) begin : g_lane
		assign lane_ctl[i] = '{en: upd, press: press_e[i], rel: rel_e[i], held: sample[i]};
		bert_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl[i]),
			.elapsed  (el_s1),
			.down_nxt (down_nxt[i]),
			.up_nxt   (up_nxt[i])
		);
	end

	always_comb begin
		qd = '0;
		qu = '0;
		for (int i = 0; i < NB; i++) begin
			if (32'(q_s1) == i) begin
				qd = down_nxt[i];
				qu = up_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (upd) begin
			held_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			query_down_ms <= qd;
			query_up_ms   <= qu;
			if (sv_s1) begin
				held_mask     <= sample;
				pressed_mask  <= press_e | ((mode_q && dir_fire) ? rpt : '0);
				released_mask <= rel_e;
			end else begin
				held_mask     <= held_q;
				pressed_mask  <= '0;
				released_mask <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_press_rel_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pressed_mask & released_mask) == '0))
		else $error("pressed and released masks overlap");

	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((pressed_mask & ~held_mask) == '0))
		else $error("pressed button not held");

	a_rel_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((released_mask & held_mask) == '0))
		else $error("released button still held");

	a_adv_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced beat not presented");
`endif

endmodule
